// File: rtl/core/dipp_pkg.sv
`default_nettype none

package dipp_pkg;

  localparam int unsigned DUTY_MIN   = 50;
  localparam int unsigned DUTY_MAX   = 950;
  localparam int unsigned DUTY_START = 640;
  localparam int unsigned DUTY_FULL  = 1000;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned GAIN_FRAC  = 8;
  localparam int unsigned GAIN_W     = 16;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_ENABLE         = 3'd0,
    REG_CURRENT_TARGET = 3'd1,
    REG_VOLTAGE_TARGET = 3'd2,
    REG_CURRENT_KP     = 3'd3,
    REG_CURRENT_KI     = 3'd4,
    REG_VOLTAGE_KP     = 3'd5,
    REG_VOLTAGE_KI     = 3'd6
  } reg_idx_t;

  localparam logic [GAIN_W-1:0] CURRENT_KP_RST = 16'd5120;
  localparam logic [GAIN_W-1:0] CURRENT_KI_RST = 16'd77;
  localparam logic [GAIN_W-1:0] VOLTAGE_KP_RST = 16'd5120;
  localparam logic [GAIN_W-1:0] VOLTAGE_KI_RST = 16'd128;

  localparam logic MODE_CURRENT = 1'b0;
  localparam logic MODE_VOLTAGE = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/dipp_if.sv
`default_nettype none

interface dipp_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] measured;

  modport source (output valid, output mode, output measured, input ready);
  modport sink (input valid, input mode, input measured, output ready);
endinterface

interface dipp_out_if ();
  logic       valid;
  logic       ready;
  logic [9:0] duty;
  logic       loop_used;

  modport source (output valid, output duty, output loop_used, input ready);
  modport sink (input valid, input duty, input loop_used, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dual_incremental_pi_pwm.sv
// Pipeline: an accepted input transaction passes the input, product and result registers in turn.
// Throughput: one transaction per cycle while the output is not stalled; each accumulator is updated
// in the result stage from the product register and its own value.
// Reset: rst_n is synchronous and active low. It clears the pipeline valid bits and the
// previous errors, loads both duty accumulators with a duty of 640 and restores register defaults.
`default_nettype none

module dual_incremental_pi_pwm
  import dipp_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  dipp_in_if.sink                in_chan,
  dipp_out_if.source             out_chan,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire [APB_ADDR_W-1:0]   paddr,
  input  wire [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int ERR_W   = SAMPLE_BITS + 1;
  localparam int DELTA_W = SAMPLE_BITS + 2;
  localparam int PROD_W  = SAMPLE_BITS + 19;
  localparam int SUM_W   = SAMPLE_BITS + 20;
  localparam int SH_L    = (FRAC_BITS >= GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
  localparam int SH_R    = (FRAC_BITS < GAIN_FRAC) ? GAIN_FRAC - FRAC_BITS : 0;
  localparam int ALIGN_W = SUM_W + SH_L;
  localparam int ACC_W   = DUTY_W + FRAC_BITS;
  localparam int WIDE_W  = ALIGN_W + 1;

  localparam logic [ACC_W-1:0] ACC_START = ACC_W'(DUTY_START) << FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] ACC_LO = WIDE_W'(DUTY_MIN) << FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] ACC_HI = WIDE_W'(DUTY_MAX) << FRAC_BITS;

  // Configuration registers.
  logic                          enable_r;
  logic signed [SAMPLE_BITS-1:0] cur_tgt_r;
  logic signed [SAMPLE_BITS-1:0] vol_tgt_r;
  logic [GAIN_W-1:0]             cur_kp_r;
  logic [GAIN_W-1:0]             cur_ki_r;
  logic [GAIN_W-1:0]             vol_kp_r;
  logic [GAIN_W-1:0]             vol_ki_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      cur_tgt_r <= '0;
      vol_tgt_r <= '0;
      cur_kp_r  <= CURRENT_KP_RST;
      cur_ki_r  <= CURRENT_KI_RST;
      vol_kp_r  <= VOLTAGE_KP_RST;
      vol_ki_r  <= VOLTAGE_KI_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:         enable_r  <= pwdata[0];
        REG_CURRENT_TARGET: cur_tgt_r <= pwdata[SAMPLE_BITS-1:0];
        REG_VOLTAGE_TARGET: vol_tgt_r <= pwdata[SAMPLE_BITS-1:0];
        REG_CURRENT_KP:     cur_kp_r  <= pwdata[GAIN_W-1:0];
        REG_CURRENT_KI:     cur_ki_r  <= pwdata[GAIN_W-1:0];
        REG_VOLTAGE_KP:     vol_kp_r  <= pwdata[GAIN_W-1:0];
        REG_VOLTAGE_KI:     vol_ki_r  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:         prdata = APB_DATA_W'(enable_r);
      REG_CURRENT_TARGET: prdata = APB_DATA_W'(unsigned'(cur_tgt_r));
      REG_VOLTAGE_TARGET: prdata = APB_DATA_W'(unsigned'(vol_tgt_r));
      REG_CURRENT_KP:     prdata = APB_DATA_W'(cur_kp_r);
      REG_CURRENT_KI:     prdata = APB_DATA_W'(cur_ki_r);
      REG_VOLTAGE_KP:     prdata = APB_DATA_W'(vol_kp_r);
      REG_VOLTAGE_KI:     prdata = APB_DATA_W'(vol_ki_r);
      default:            prdata = '0;
    endcase
  end

  // Pipeline handshake.
  logic a_valid_r, b_valid_r, out_valid_r;
  logic a_load, b_load, c_load;

  assign c_load        = !out_valid_r || out_chan.ready;
  assign b_load        = !b_valid_r || c_load;
  assign a_load        = !a_valid_r || b_load;
  assign in_chan.ready = a_load;

  // Input stage. Samples that arrive while disabled are dropped here.
  logic                          a_mode_r;
  logic signed [SAMPLE_BITS-1:0] a_meas_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_load) begin
      a_valid_r <= in_chan.valid && enable_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_mode_r <= in_chan.mode;
      a_meas_r <= in_chan.measured;
    end
  end

  // Error and product stage.
  logic signed [ERR_W-1:0]       cur_prev_r, vol_prev_r;
  logic signed [SAMPLE_BITS-1:0] sel_tgt;
  logic signed [ERR_W-1:0]       sel_prev;
  logic [GAIN_W-1:0]             sel_kp, sel_ki;
  logic signed [ERR_W-1:0]       err;
  logic signed [DELTA_W-1:0]     delta;
  logic signed [PROD_W-1:0]      delta_x, err_x, kp_x, ki_x;
  logic signed [PROD_W-1:0]      pk_nxt, pi_nxt;
  logic signed [PROD_W-1:0]      b_pk_r, b_pi_r;
  logic                          b_mode_r;
  logic                          b_step;

  always_comb begin
    if (a_mode_r == MODE_VOLTAGE) begin
      sel_tgt  = vol_tgt_r;
      sel_prev = vol_prev_r;
      sel_kp   = vol_kp_r;
      sel_ki   = vol_ki_r;
    end else begin
      sel_tgt  = cur_tgt_r;
      sel_prev = cur_prev_r;
      sel_kp   = cur_kp_r;
      sel_ki   = cur_ki_r;
    end
  end

  assign err     = ERR_W'(sel_tgt) - ERR_W'(a_meas_r);
  assign delta   = DELTA_W'(err) - DELTA_W'(sel_prev);
  assign delta_x = PROD_W'(delta);
  assign err_x   = PROD_W'(err);
  assign kp_x    = signed'(PROD_W'(sel_kp));
  assign ki_x    = signed'(PROD_W'(sel_ki));
  assign pk_nxt  = delta_x * kp_x;
  assign pi_nxt  = err_x * ki_x;
  assign b_step  = b_load && a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r  <= 1'b0;
      cur_prev_r <= '0;
      vol_prev_r <= '0;
    end else begin
      if (b_load) begin
        b_valid_r <= a_valid_r;
      end
      if (b_step && a_mode_r == MODE_CURRENT) begin
        cur_prev_r <= err;
      end
      if (b_step && a_mode_r == MODE_VOLTAGE) begin
        vol_prev_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_mode_r <= a_mode_r;
      b_pk_r   <= pk_nxt;
      b_pi_r   <= pi_nxt;
    end
  end

  // Accumulate, clamp and result stage.
  logic [ACC_W-1:0]           cur_acc_r, vol_acc_r;
  logic [ACC_W-1:0]           sel_acc;
  logic signed [SUM_W-1:0]    prod_sum;
  logic signed [ALIGN_W-1:0]  aligned;
  logic signed [WIDE_W-1:0]   acc_sum;
  logic signed [WIDE_W-1:0]   acc_clamped;
  logic [ACC_W-1:0]           acc_nxt;
  logic [DUTY_W-1:0]          duty_int;
  logic [DUTY_W-1:0]          duty_nxt;
  logic [DUTY_W-1:0]          out_duty_r;
  logic                       out_loop_r;
  logic                       c_step;

  assign sel_acc  = (b_mode_r == MODE_VOLTAGE) ? vol_acc_r : cur_acc_r;
  assign prod_sum = SUM_W'(b_pk_r) + SUM_W'(b_pi_r);
  assign aligned  = (ALIGN_W'(prod_sum) <<< SH_L) >>> SH_R;
  assign acc_sum  = WIDE_W'(aligned) + signed'(WIDE_W'(sel_acc));

  always_comb begin
    priority if (acc_sum > ACC_HI) begin
      acc_clamped = ACC_HI;
    end else if (acc_sum < ACC_LO) begin
      acc_clamped = ACC_LO;
    end else begin
      acc_clamped = acc_sum;
    end
  end

  assign acc_nxt  = acc_clamped[ACC_W-1:0];
  assign duty_int = acc_nxt[ACC_W-1:FRAC_BITS];
  assign duty_nxt = (b_mode_r == MODE_VOLTAGE) ? DUTY_W'(DUTY_FULL) - duty_int : duty_int;
  assign c_step   = c_load && b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_acc_r   <= ACC_START;
      vol_acc_r   <= ACC_START;
    end else begin
      if (c_load) begin
        out_valid_r <= b_valid_r;
      end
      if (c_step && b_mode_r == MODE_CURRENT) begin
        cur_acc_r <= acc_nxt;
      end
      if (c_step && b_mode_r == MODE_VOLTAGE) begin
        vol_acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      out_duty_r <= duty_nxt;
      out_loop_r <= b_mode_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.duty      = out_duty_r;
  assign out_chan.loop_used = out_loop_r;

  // The accumulators never leave the clamp window.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cur_acc_r >= ACC_LO[ACC_W-1:0]) && (cur_acc_r <= ACC_HI[ACC_W-1:0]))
    else $error("current accumulator outside its clamp window");

  assert property (@(posedge clk) disable iff (!rst_n)
    (vol_acc_r >= ACC_LO[ACC_W-1:0]) && (vol_acc_r <= ACC_HI[ACC_W-1:0]))
    else $error("voltage accumulator outside its clamp window");

  // A sample taken while disabled must not enter the pipeline.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && a_load && !enable_r) |=> !a_valid_r)
    else $error("disabled sample entered the pipeline");

  // The current accumulator holds unless a current-loop transaction updates it.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(c_step && b_mode_r == MODE_CURRENT) |=> $stable(cur_acc_r))
    else $error("current accumulator changed without a current-loop transaction");

  // A delivered duty stays within the PWM window.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_duty_r >= DUTY_W'(DUTY_MIN)) && (out_duty_r <= DUTY_W'(DUTY_MAX)))
    else $error("duty outside the PWM window");

endmodule

`default_nettype wire
